@@ sv/sqmp_pkg.sv @@
// ----------------------------------------------------------------------------
// sqmp_pkg
// Types and constants shared by the square matrix power unit and its checker.
// ----------------------------------------------------------------------------
package sqmp_pkg;

   localparam int DATA_W = 32;
   localparam int DIM_W  = 3;
   localparam int IDX_W  = 2;
   localparam int EXP_W  = 16;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_POWER = 1'b1;

   // bank 0 of the work RAM holds the stored matrix
   localparam logic [1:0] BANK_BASE = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_MUL,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_PRODUCT,
      OP_SQUARE,
      OP_COPY
   } op_type;

   typedef struct packed {
      logic                     kind;
      logic [IDX_W-1:0]         entry_row;
      logic [IDX_W-1:0]         entry_col;
      logic signed [DATA_W-1:0] entry_value;
      logic [EXP_W-1:0]         exponent;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_row;
      logic [IDX_W-1:0]         out_col;
      logic signed [DATA_W-1:0] out_value;
      logic                     last;
   } rsp_type;

endpackage

@@ sv/square_matrix_power_unit.sv @@
// ----------------------------------------------------------------------------
// square_matrix_power_unit
// Stores a square integer matrix and raises it to a power in place, then
// streams out every entry in row-major order.
// ----------------------------------------------------------------------------
// A load item writes the stored matrix and busy stays low. A power item raises the
// matrix by square-and-multiply on one shared 32x32 multiplier: each matrix
// product runs d*d*d multiply-accumulate steps, where d is the dimension in
// use, and then drains the multiply-accumulate pipeline. An
// exponent e >= 2 needs floor(log2 e) squarings and popcount(e)-1 products,
// then a copy into the stored matrix; the step state runs between passes.
// Emission reads one entry per cycle, so the d*d results come on consecutive
// cycles, the first after the RAM read stage and the result register.
// Results are strobed for one cycle each and cannot be held off; busy drops
// as the last entry is read, in the cycle before its strobe.
// The dimension register is sampled when a power item is accepted.
// ----------------------------------------------------------------------------
module square_matrix_power_unit #(
   parameter int MAX_DIM = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  sqmp_pkg::req_type            req_item,
   output logic                         rsp_strobe,
   output sqmp_pkg::rsp_type            rsp_item,
   input  logic                         csr_we,
   input  logic [sqmp_pkg::DIM_W-1:0]   csr_wdata
);

   localparam int CELLS  = MAX_DIM * MAX_DIM;
   localparam int IW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CW     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int DW     = $clog2(MAX_DIM + 1);
   localparam int AW     = 2 + CW;
   localparam int DEPTH  = 1 << AW;
   localparam int DATA_W = sqmp_pkg::DATA_W;

   function automatic logic [CW-1:0] cell_of(input logic [IW-1:0] row,
                                             input logic [IW-1:0] col);
      return CW'(int'(row) * MAX_DIM + int'(col));
   endfunction

   // any work bank that holds neither the square nor the running product
   function automatic logic [1:0] free_bank(input logic [1:0] sq,
                                            input logic [1:0] rp);
      logic [1:0] pick;
      pick = 2'd3;
      for (int b = 3; b >= 1; b--) begin
         if (2'(b) != sq && 2'(b) != rp) begin
            pick = 2'(b);
         end
      end
      return pick;
   endfunction

   // control state
   sqmp_pkg::state_type     state_ff, state_in;
   sqmp_pkg::op_type        op_ff, op_in;
   logic [sqmp_pkg::DIM_W-1:0] dim_ff, dim_in;
   logic [DW-1:0]           d_ff, d_in;
   logic [sqmp_pkg::EXP_W-1:0] rc_ff, rc_in;
   logic                    have_ff, have_in;
   logic                    sqphase_ff, sqphase_in;
   logic [1:0]              sq_bank_ff, sq_bank_in;
   logic [1:0]              rp_bank_ff, rp_bank_in;
   logic [1:0]              dst_bank_ff, dst_bank_in;
   logic [1:0]              a_bank_ff, a_bank_in;
   logic [1:0]              b_bank_ff, b_bank_in;
   logic [IW-1:0]           i_ff, i_in;
   logic [IW-1:0]           j_ff, j_in;
   logic [IW-1:0]           k_ff, k_in;
   logic [CELLS-1:0]        base_vld_ff, base_vld_in;

   // pipeline
   logic                    s1_vld_ff, s1_vld_in;
   logic                    s1_emit_ff, s1_emit_in;
   logic                    s1_first_ff, s1_first_in;
   logic                    s1_last_ff, s1_last_in;
   logic [CW-1:0]           s1_cell_ff, s1_cell_in;
   logic [IW-1:0]           s1_row_ff, s1_row_in;
   logic [IW-1:0]           s1_col_ff, s1_col_in;
   logic                    s1_elast_ff, s1_elast_in;
   logic                    a_zero_ff, a_zero_in;
   logic                    b_zero_ff, b_zero_in;
   logic                    s2_vld_ff, s2_vld_in;
   logic                    s2_first_ff, s2_first_in;
   logic                    s2_last_ff, s2_last_in;
   logic [CW-1:0]           s2_cell_ff, s2_cell_in;
   logic [DATA_W-1:0]       prod_ff, prod_in;
   logic [DATA_W-1:0]       acc_ff, acc_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   sqmp_pkg::rsp_type       rsp_item_ff, rsp_item_in;

   // RAM
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [DATA_W-1:0]       wr_data;
   logic [AW-1:0]           rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0]       rd_data_a, rd_data_b;

   logic [IW-1:0]           last_idx, kmax;
   logic [DW-1:0]           d_eff;
   logic                    accept;
   logic                    load_hit;
   logic [CW-1:0]           load_cell;
   logic [DATA_W-1:0]       a_val, b_val, sum;

   sqmp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign accept   = start && (state_ff == sqmp_pkg::ST_IDLE);
   assign busy     = (state_ff != sqmp_pkg::ST_IDLE);
   assign last_idx = IW'(d_ff - DW'(1));
   assign kmax     = (op_ff == sqmp_pkg::OP_COPY) ? '0 : last_idx;
   assign load_hit = (int'(req_item.entry_row) < MAX_DIM)
                  && (int'(req_item.entry_col) < MAX_DIM);
   assign load_cell = CW'(int'(req_item.entry_row) * MAX_DIM
                        + int'(req_item.entry_col));

   always_comb begin
      if (dim_ff == '0) begin
         d_eff = DW'(1);
      end else if (int'(dim_ff) > MAX_DIM) begin
         d_eff = DW'(MAX_DIM);
      end else begin
         d_eff = DW'(dim_ff);
      end
   end

   // operand select; unwritten base entries read as zero
   assign a_val = a_zero_ff ? '0 : rd_data_a;
   assign b_val = (op_ff == sqmp_pkg::OP_COPY) ? DATA_W'(1)
                : (b_zero_ff ? '0 : rd_data_b);
   assign prod_in = a_val * b_val;
   assign sum     = s2_first_ff ? prod_ff : acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sqmp_pkg::ST_IDLE;
         op_ff         <= sqmp_pkg::OP_PRODUCT;
         dim_ff        <= sqmp_pkg::DIM_W'(4);
         d_ff          <= DW'(1);
         rc_ff         <= '0;
         have_ff       <= 1'b0;
         sqphase_ff    <= 1'b0;
         sq_bank_ff    <= sqmp_pkg::BANK_BASE;
         rp_bank_ff    <= sqmp_pkg::BANK_BASE;
         dst_bank_ff   <= sqmp_pkg::BANK_BASE;
         a_bank_ff     <= sqmp_pkg::BANK_BASE;
         b_bank_ff     <= sqmp_pkg::BANK_BASE;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         base_vld_ff   <= '0;
         s1_vld_ff     <= 1'b0;
         s1_emit_ff    <= 1'b0;
         s2_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         dim_ff        <= dim_in;
         d_ff          <= d_in;
         rc_ff         <= rc_in;
         have_ff       <= have_in;
         sqphase_ff    <= sqphase_in;
         sq_bank_ff    <= sq_bank_in;
         rp_bank_ff    <= rp_bank_in;
         dst_bank_ff   <= dst_bank_in;
         a_bank_ff     <= a_bank_in;
         b_bank_ff     <= b_bank_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         base_vld_ff   <= base_vld_in;
         s1_vld_ff     <= s1_vld_in;
         s1_emit_ff    <= s1_emit_in;
         s2_vld_ff     <= s2_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= s1_first_in;
      s1_last_ff  <= s1_last_in;
      s1_cell_ff  <= s1_cell_in;
      s1_row_ff   <= s1_row_in;
      s1_col_ff   <= s1_col_in;
      s1_elast_ff <= s1_elast_in;
      a_zero_ff   <= a_zero_in;
      b_zero_ff   <= b_zero_in;
      s2_first_ff <= s2_first_in;
      s2_last_ff  <= s2_last_in;
      s2_cell_ff  <= s2_cell_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      dim_in      = csr_we ? csr_wdata : dim_ff;
      d_in        = d_ff;
      rc_in       = rc_ff;
      have_in     = have_ff;
      sqphase_in  = sqphase_ff;
      sq_bank_in  = sq_bank_ff;
      rp_bank_in  = rp_bank_ff;
      dst_bank_in = dst_bank_ff;
      a_bank_in   = a_bank_ff;
      b_bank_in   = b_bank_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      s1_vld_in   = 1'b0;
      s1_emit_in  = 1'b0;
      s1_first_in = (k_ff == '0);
      s1_last_in  = (k_ff == kmax);
      s1_cell_in  = cell_of(i_ff, j_ff);
      s1_row_in   = i_ff;
      s1_col_in   = j_ff;
      s1_elast_in = (i_ff == last_idx) && (j_ff == last_idx);
      rd_addr_a   = {a_bank_ff, cell_of(i_ff, k_ff)};
      rd_addr_b   = {b_bank_ff, cell_of(k_ff, j_ff)};

      case (state_ff)
         sqmp_pkg::ST_IDLE: begin
            if (accept && req_item.kind == sqmp_pkg::KIND_POWER) begin
               d_in       = d_eff;
               rc_in      = req_item.exponent;
               have_in    = 1'b0;
               sqphase_in = 1'b0;
               sq_bank_in = sqmp_pkg::BANK_BASE;
               i_in       = '0;
               j_in       = '0;
               k_in       = '0;
               if (req_item.exponent < sqmp_pkg::EXP_W'(2)) begin
                  state_in = sqmp_pkg::ST_EMIT;
               end else begin
                  state_in = sqmp_pkg::ST_STEP;
               end
            end
         end
         sqmp_pkg::ST_STEP: begin
            if (!sqphase_ff) begin
               if (rc_ff[0] && have_ff) begin
                  op_in       = sqmp_pkg::OP_PRODUCT;
                  a_bank_in   = rp_bank_ff;
                  b_bank_in   = sq_bank_ff;
                  dst_bank_in = free_bank(sq_bank_ff, rp_bank_ff);
                  state_in    = sqmp_pkg::ST_MUL;
               end else begin
                  if (rc_ff[0]) begin
                     rp_bank_in = sq_bank_ff;
                     have_in    = 1'b1;
                  end
                  rc_in      = rc_ff >> 1;
                  sqphase_in = 1'b1;
               end
            end else if (rc_ff != '0) begin
               op_in       = sqmp_pkg::OP_SQUARE;
               a_bank_in   = sq_bank_ff;
               b_bank_in   = sq_bank_ff;
               dst_bank_in = free_bank(sq_bank_ff, rp_bank_ff);
               state_in    = sqmp_pkg::ST_MUL;
            end else begin
               op_in       = sqmp_pkg::OP_COPY;
               a_bank_in   = rp_bank_ff;
               b_bank_in   = rp_bank_ff;
               dst_bank_in = sqmp_pkg::BANK_BASE;
               state_in    = sqmp_pkg::ST_MUL;
            end
         end
         sqmp_pkg::ST_MUL: begin
            s1_vld_in = 1'b1;
            if (op_ff == sqmp_pkg::OP_COPY) begin
               rd_addr_a = {a_bank_ff, cell_of(i_ff, j_ff)};
            end
            if (k_ff == kmax) begin
               k_in = '0;
               if (j_ff == last_idx) begin
                  j_in = '0;
                  if (i_ff == last_idx) begin
                     i_in     = '0;
                     state_in = sqmp_pkg::ST_DRAIN;
                  end else begin
                     i_in = i_ff + IW'(1);
                  end
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         sqmp_pkg::ST_DRAIN: begin
            // wait for the last write of the product to land
            if (!s1_vld_ff && !s2_vld_ff) begin
               case (op_ff)
                  sqmp_pkg::OP_PRODUCT: begin
                     rp_bank_in = dst_bank_ff;
                     rc_in      = rc_ff >> 1;
                     sqphase_in = 1'b1;
                     state_in   = sqmp_pkg::ST_STEP;
                  end
                  sqmp_pkg::OP_SQUARE: begin
                     sq_bank_in = dst_bank_ff;
                     sqphase_in = 1'b0;
                     state_in   = sqmp_pkg::ST_STEP;
                  end
                  default: begin
                     state_in = sqmp_pkg::ST_EMIT;
                  end
               endcase
            end
         end
         sqmp_pkg::ST_EMIT: begin
            s1_emit_in = 1'b1;
            rd_addr_a  = {sqmp_pkg::BANK_BASE, cell_of(i_ff, j_ff)};
            if (j_ff == last_idx) begin
               j_in = '0;
               if (i_ff == last_idx) begin
                  i_in     = '0;
                  state_in = sqmp_pkg::ST_IDLE;
               end else begin
                  i_in = i_ff + IW'(1);
               end
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         default: begin
            state_in = sqmp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      a_zero_in = (rd_addr_a[AW-1:CW] == sqmp_pkg::BANK_BASE)
               && !base_vld_ff[rd_addr_a[CW-1:0]];
      b_zero_in = (rd_addr_b[AW-1:CW] == sqmp_pkg::BANK_BASE)
               && !base_vld_ff[rd_addr_b[CW-1:0]];
   end

   // multiply-accumulate and write-back
   assign s2_vld_in   = s1_vld_ff;
   assign s2_first_in = s1_first_ff;
   assign s2_last_in  = s1_last_ff;
   assign s2_cell_in  = s1_cell_ff;
   assign acc_in      = s2_vld_ff ? sum : acc_ff;

   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = {dst_bank_ff, s2_cell_ff};
      wr_data     = sum;
      base_vld_in = base_vld_ff;
      if (s2_vld_ff && s2_last_ff) begin
         wr_en = 1'b1;
      end else if (accept && req_item.kind == sqmp_pkg::KIND_LOAD && load_hit) begin
         wr_en   = 1'b1;
         wr_addr = {sqmp_pkg::BANK_BASE, load_cell};
         wr_data = req_item.entry_value;
      end
      if (wr_en && wr_addr[AW-1:CW] == sqmp_pkg::BANK_BASE) begin
         base_vld_in[wr_addr[CW-1:0]] = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_strobe_in         = s1_emit_ff;
      rsp_item_in.out_row   = sqmp_pkg::IDX_W'(s1_row_ff);
      rsp_item_in.out_col   = sqmp_pkg::IDX_W'(s1_col_ff);
      rsp_item_in.out_value = a_val;
      rsp_item_in.last      = s1_elast_ff;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

@@ sv/sqmp_ram.sv @@
// ----------------------------------------------------------------------------
// sqmp_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sqmp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

@@ sv/sqmp_checker.sv @@
// ----------------------------------------------------------------------------
// sqmp_checker
// Port-level checks on the square matrix power unit, bound to the top level.
// ----------------------------------------------------------------------------
module sqmp_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  sqmp_pkg::req_type   req_item,
   input  logic                rsp_strobe,
   input  sqmp_pkg::rsp_type   rsp_item
);

   // a load transfer never raises busy
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.kind == sqmp_pkg::KIND_LOAD) |=> !busy)
      else $error("busy raised by a load transfer");

   a_power_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.kind == sqmp_pkg::KIND_POWER) |=> busy)
      else $error("power transfer did not raise busy");

   // entries of one matrix stream back to back
   a_stream_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |=> rsp_strobe)
      else $error("gap inside a result stream");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last) |=> !rsp_strobe)
      else $error("result right after the last entry");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("activity right after reset");

endmodule

bind square_matrix_power_unit sqmp_checker u_sqmp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

@@ verif/square_matrix_power_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// square_matrix_power_unit_tb
// Self-checking bench for the square matrix power unit: loads entries, raises
// the stored matrix to random exponents at every dimension setting, and
// compares each streamed entry against a square-and-multiply predictor.
// ----------------------------------------------------------------------------
module square_matrix_power_unit_tb;

   localparam int STORE_DIM = 4;
   localparam int CELLS     = STORE_DIM * STORE_DIM;

   typedef logic [CELLS-1:0][sqmp_pkg::DATA_W-1:0] matrix_cells_type;

   class matrix_power_scoreboard;
      logic [sqmp_pkg::DIM_W-1:0] dim_reg;
      matrix_cells_type           stored;
      sqmp_pkg::rsp_type          entry_queue[$];
      int unsigned                fail_count;

      function new();
         dim_reg    = sqmp_pkg::DIM_W'(4);
         stored     = '0;
         fail_count = 0;
      endfunction

      function void write_dim(logic [sqmp_pkg::DIM_W-1:0] value);
         dim_reg = value;
      endfunction

      function int unsigned active_dim();
         if (dim_reg == 0) return 1;
         if (dim_reg > STORE_DIM) return STORE_DIM;
         return dim_reg;
      endfunction

      function int unsigned pending();
         return entry_queue.size();
      endfunction

      // only the top-left d x d block is computed; the rest follows lhs
      function matrix_cells_type matrix_product(matrix_cells_type lhs,
                                                matrix_cells_type rhs,
                                                int unsigned d);
         matrix_cells_type            dst;
         logic [sqmp_pkg::DATA_W-1:0] acc;
         dst = lhs;
         for (int i = 0; i < d; i++) begin
            for (int j = 0; j < d; j++) begin
               acc = '0;
               for (int k = 0; k < d; k++)
                  acc = acc + lhs[i*STORE_DIM+k] * rhs[k*STORE_DIM+j];
               dst[i*STORE_DIM+j] = acc;
            end
         end
         return dst;
      endfunction

      function void raise_stored(logic [sqmp_pkg::EXP_W-1:0] exponent, int unsigned d);
         matrix_cells_type           square;
         matrix_cells_type           running;
         logic [sqmp_pkg::EXP_W-1:0] bits_left;
         bit                         have_running;
         if (exponent < 2) return;
         square       = stored;
         running      = '0;
         have_running = 1'b0;
         bits_left    = exponent;
         while (bits_left != 0) begin
            if (bits_left[0]) begin
               if (!have_running) begin
                  running      = square;
                  have_running = 1'b1;
               end else begin
                  running = matrix_product(running, square, d);
               end
            end
            bits_left = bits_left >> 1;
            if (bits_left != 0) square = matrix_product(square, square, d);
         end
         for (int i = 0; i < d; i++)
            for (int j = 0; j < d; j++)
               stored[i*STORE_DIM+j] = running[i*STORE_DIM+j];
      endfunction

      function void note_input(sqmp_pkg::req_type item);
         int unsigned       d;
         sqmp_pkg::rsp_type entry;
         if (item.kind == sqmp_pkg::KIND_LOAD) begin
            stored[item.entry_row*STORE_DIM+item.entry_col] = item.entry_value;
            return;
         end
         d = active_dim();
         raise_stored(item.exponent, d);
         for (int i = 0; i < d; i++) begin
            for (int j = 0; j < d; j++) begin
               entry.out_row   = sqmp_pkg::IDX_W'(i);
               entry.out_col   = sqmp_pkg::IDX_W'(j);
               entry.out_value = stored[i*STORE_DIM+j];
               entry.last      = (i == d - 1) && (j == d - 1);
               entry_queue.push_back(entry);
            end
         end
      endfunction

      function void check_result(sqmp_pkg::rsp_type got);
         sqmp_pkg::rsp_type want;
         if (entry_queue.size() == 0) begin
            $error("unexpected result: row %0d col %0d value %0d last %0d",
                   got.out_row, got.out_col, got.out_value, got.last);
            fail_count++;
            return;
         end
         want = entry_queue.pop_front();
         if (got.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
            fail_count++;
         end
         if (got.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
            fail_count++;
         end
         if (got.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
            fail_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_count++;
         end
      endfunction
   endclass

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       start     = 1'b0;
   logic                       busy;
   sqmp_pkg::req_type          req_item  = '0;
   logic                       rsp_strobe;
   sqmp_pkg::rsp_type          rsp_item;
   logic                       csr_we    = 1'b0;
   logic [sqmp_pkg::DIM_W-1:0] csr_wdata = '0;

   matrix_power_scoreboard sb = new();
   bit no_idle = 1'b0;

   square_matrix_power_unit #(.MAX_DIM(STORE_DIM)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_item);
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [sqmp_pkg::DATA_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return sqmp_pkg::DATA_W'($signed($urandom_range(0, 6)) - 3);
      if (r < 50) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      return $urandom;
   endfunction

   function automatic logic [sqmp_pkg::EXP_W-1:0] pick_exponent();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return sqmp_pkg::EXP_W'($urandom_range(0, 1));
      if (r < 60) return sqmp_pkg::EXP_W'($urandom_range(2, 8));
      if (r < 85) return sqmp_pkg::EXP_W'($urandom_range(9, 255));
      return sqmp_pkg::EXP_W'($urandom);
   endfunction

   // start stays high across back-to-back transfers when no idle gap is picked
   task automatic send_item(input sqmp_pkg::req_type item);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      sb.note_input(item);
   endtask

   task automatic load_entry(input int unsigned row, input int unsigned col,
                             input logic [sqmp_pkg::DATA_W-1:0] value);
      sqmp_pkg::req_type item;
      item.kind        = sqmp_pkg::KIND_LOAD;
      item.entry_row   = sqmp_pkg::IDX_W'(row);
      item.entry_col   = sqmp_pkg::IDX_W'(col);
      item.entry_value = value;
      item.exponent    = sqmp_pkg::EXP_W'($urandom);
      send_item(item);
   endtask

   task automatic raise_power(input logic [sqmp_pkg::EXP_W-1:0] exponent);
      sqmp_pkg::req_type item;
      item.kind        = sqmp_pkg::KIND_POWER;
      item.entry_row   = sqmp_pkg::IDX_W'($urandom);
      item.entry_col   = sqmp_pkg::IDX_W'($urandom);
      item.entry_value = $urandom;
      item.exponent    = exponent;
      send_item(item);
   endtask

   // dimension changes only once the unit has gone quiet
   task automatic set_dimension(input logic [sqmp_pkg::DIM_W-1:0] value);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_dim(value);
   endtask

   task automatic run_phase(input int unsigned quota);
      int unsigned sent;
      int unsigned d;
      int unsigned r;
      int unsigned n;
      sent = 0;
      d    = sb.active_dim();
      while (sent < quota) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            for (int i = 0; i < d; i++)
               for (int j = 0; j < d; j++)
                  load_entry(i, j, pick_value());
            raise_power(pick_exponent());
            sent += d * d + 1;
         end else if (r < 80) begin
            raise_power(pick_exponent());
            sent++;
         end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
               load_entry($urandom_range(0, 3), $urandom_range(0, 3), pick_value());
            sent += n;
            if ($urandom_range(0, 1)) begin
               raise_power(pick_exponent());
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [sqmp_pkg::DIM_W-1:0] phase_dims[10];
      phase_dims = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd5, 3'd6, 3'd4, 3'd2, 3'd4};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // cleared store, then corner extremes at the reset dimension
      raise_power(16'd0);
      load_entry(0, 0, 32'h7fff_ffff);
      load_entry(0, 3, 32'h8000_0000);
      load_entry(3, 0, 32'hffff_ffff);
      load_entry(3, 3, 32'h0000_0001);
      raise_power(16'd1);
      raise_power(16'd2);
      load_entry(1, 2, 32'h0000_ffff);
      raise_power(16'hffff);

      // entries outside the active block must survive a power
      set_dimension(3'd1);
      load_entry(0, 0, 32'd3);
      load_entry(3, 3, 32'd5);
      raise_power(16'd3);
      raise_power(16'hffff);
      set_dimension(3'd4);
      raise_power(16'd0);
      set_dimension(3'd0);
      raise_power(16'd2);
      set_dimension(3'd7);
      raise_power(16'd1);

      foreach (phase_dims[p]) begin
         set_dimension(phase_dims[p]);
         no_idle = ($urandom_range(0, 3) == 0);
         run_phase(26);
      end

      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/sqmp_pkg.sv
sv/sqmp_ram.sv
sv/square_matrix_power_unit.sv
sv/sqmp_checker.sv
verif/square_matrix_power_unit_tb.sv
